// ----- design/ppioba_pkg.sv -----
// ----------------------------------------------------------------------------
// ppioba_pkg
// Shared types and constants for the per-process io byte accounting core.
// ----------------------------------------------------------------------------
package ppioba_pkg;

  localparam logic [1:0] MODE_ACCESS  = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_READOUT = 2'd2;
  localparam logic [1:0] MODE_RESTART = 2'd3;

  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;

  localparam logic [1:0] KIND_ENTRY    = 2'd0;
  localparam logic [1:0] KIND_OVERFLOW = 2'd1;
  localparam logic [1:0] KIND_EMPTY    = 2'd2;

  localparam logic REG_ENABLED = 1'b0;
  localparam logic REG_WINDOW  = 1'b1;

  localparam logic [13:0] WINDOW_MAX    = 14'd10000;
  localparam logic [13:0] WINDOW_RESET  = 14'd5000;
  localparam logic [13:0] TICK_SAT      = 14'h3fff;
  localparam int          KB_SHIFT      = 10;

  typedef struct packed {
    logic [21:0] pid;
    logic [63:0] start;
    logic [63:0] rd;
    logic [63:0] wr;
  } entry_t;

  typedef struct packed {
    logic        capture;
    logic        ins;
    logic        drain;
    logic        add;
    logic        add_rd;
    logic        add_wr;
    logic [31:0] bytes;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DRAIN,
    ST_TAIL
  } state_t;

endpackage

// ----- design/ppioba_cell.sv -----
// ----------------------------------------------------------------------------
// ppioba_cell
// One table slot: key compare, read/write byte counters, shifts to neighbors.
// ----------------------------------------------------------------------------
module ppioba_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  ppioba_pkg::cell_ctrl_t ctrl,
  input  logic                   valid,
  input  logic [21:0]            key_pid,
  input  logic [63:0]            key_start,
  input  ppioba_pkg::entry_t     prev_entry,
  input  ppioba_pkg::entry_t     next_entry,
  output ppioba_pkg::entry_t     entry,
  output logic                   hit
);
  import ppioba_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.capture) begin
      hit <= valid && (entry.pid == key_pid) && (entry.start == key_start);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      entry <= prev_entry;
    end else if (ctrl.drain) begin
      entry <= next_entry;
    end else if (ctrl.add && hit) begin
      if (ctrl.add_rd) begin
        entry.rd <= entry.rd + {32'd0, ctrl.bytes};
      end
      if (ctrl.add_wr) begin
        entry.wr <= entry.wr + {32'd0, ctrl.bytes};
      end
    end
  end

endmodule

// ----- design/per_process_io_byte_accounting_core.sv -----
// ----------------------------------------------------------------------------
// per_process_io_byte_accounting_core
// Per-process read/write byte accounting table with readout in KB.
// ----------------------------------------------------------------------------
// Items enter on start while busy is low. For an access, the key is
// compared in every slot at the transfer, and the update (counter add,
// append of a new slot, or overflow add) happens in the next cycle.
// A readout shifts the slot chain toward slot 0, one row per cycle, newest
// entry first, then the overflow row if nonzero, or one empty row when there
// is nothing to report. Each row shows on the result ports for one cycle
// with result_valid high, in the cycle after it leaves the chain.
// The receiver cannot stall.
// Configuration is written on the cfg channel, always ready; writing enabled
// also clears the table and restarts the window.
// Reset: accounting off, table empty, window closed until a restart.
// ----------------------------------------------------------------------------
module per_process_io_byte_accounting_core #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [21:0] process_id,
  input  logic [63:0] start_time,
  input  logic [2:0]  opcode,
  input  logic [31:0] access_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [13:0] cfg_data,
  output logic        result_valid,
  output logic [1:0]  row_kind,
  output logic [21:0] row_process_id,
  output logic [53:0] read_kb,
  output logic [53:0] write_kb,
  output logic        last_row
);
  import ppioba_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t        state, state_next;
  logic          enabled;
  logic [13:0]   window_ticks;
  logic [13:0]   ticks_elapsed;
  logic [CW-1:0] entry_count;
  logic [63:0]   ovf_rd, ovf_wr;
  logic          act;
  logic          lat_rd, lat_wr;
  logic [21:0]   lat_pid;
  logic [63:0]   lat_start;
  logic [31:0]   lat_bytes;

  logic          accept, cfg_xfer, ovf_nz, full, any_hit, clear, ovf_add;
  cell_ctrl_t    ctrl;
  entry_t        cells [TABLE_DEPTH];
  entry_t        new_entry;
  logic [TABLE_DEPTH-1:0] hits;
  logic [TABLE_DEPTH-1:0] cell_valid;

  logic          emit;
  logic [1:0]    kind_next;
  logic [21:0]   pid_next;
  logic [63:0]   rd_next, wr_next;
  logic          last_next;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign ovf_nz    = (|ovf_rd) || (|ovf_wr);
  assign full      = (entry_count == CW'(TABLE_DEPTH));
  assign any_hit   = |hits;

  assign new_entry.pid   = lat_pid;
  assign new_entry.start = lat_start;
  assign new_entry.rd    = lat_rd ? {32'd0, lat_bytes} : 64'd0;
  assign new_entry.wr    = lat_wr ? {32'd0, lat_bytes} : 64'd0;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      entry_t prev_e, next_e;
      assign cell_valid[gi] = (CW'(gi) < entry_count);
      if (gi == 0) begin : g_first
        assign prev_e = new_entry;
      end else begin : g_mid
        assign prev_e = cells[gi-1];
      end
      if (gi == TABLE_DEPTH - 1) begin : g_last
        assign next_e = cells[gi];
      end else begin : g_inner
        assign next_e = cells[gi+1];
      end
      ppioba_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .valid      (cell_valid[gi]),
        .key_pid    (process_id),
        .key_start  (start_time),
        .prev_entry (prev_e),
        .next_entry (next_e),
        .entry      (cells[gi]),
        .hit        (hits[gi])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && mode == MODE_ACCESS) begin
          state_next = ST_UPDATE;
        end else if (accept && mode == MODE_READOUT) begin
          state_next = (entry_count != '0) ? ST_DRAIN : ST_TAIL;
        end
      end
      ST_UPDATE: state_next = ST_IDLE;
      ST_DRAIN: begin
        if (entry_count == CW'(1)) begin
          state_next = ovf_nz ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.capture = accept && (mode == MODE_ACCESS);
    ctrl.ins     = 1'b0;
    ctrl.drain   = 1'b0;
    ctrl.add     = 1'b0;
    ctrl.add_rd  = lat_rd;
    ctrl.add_wr  = lat_wr;
    ctrl.bytes   = lat_bytes;
    ovf_add      = 1'b0;
    clear        = 1'b0;
    emit         = 1'b0;
    kind_next    = KIND_ENTRY;
    pid_next     = cells[0].pid;
    rd_next      = cells[0].rd;
    wr_next      = cells[0].wr;
    last_next    = 1'b0;
    case (state)
      ST_IDLE: begin
        clear = accept && (mode == MODE_RESTART);
      end
      ST_UPDATE: begin
        ctrl.add = act;
        ctrl.ins = act && !any_hit && !full;
        ovf_add  = act && !any_hit && full;
      end
      ST_DRAIN: begin
        emit        = 1'b1;
        ctrl.drain  = 1'b1;
        last_next   = (entry_count == CW'(1)) && !ovf_nz;
        clear       = last_next;
      end
      ST_TAIL: begin
        emit      = 1'b1;
        last_next = 1'b1;
        clear     = 1'b1;
        pid_next  = 22'd0;
        if (ovf_nz) begin
          kind_next = KIND_OVERFLOW;
          rd_next   = ovf_rd;
          wr_next   = ovf_wr;
        end else begin
          kind_next = KIND_EMPTY;
          rd_next   = 64'd0;
          wr_next   = 64'd0;
        end
      end
      default: begin
        clear = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      enabled       <= 1'b0;
      window_ticks  <= WINDOW_RESET;
      ticks_elapsed <= TICK_SAT;
      entry_count   <= '0;
      ovf_rd        <= 64'd0;
      ovf_wr        <= 64'd0;
      act           <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= emit;
      if (ctrl.capture) begin
        act <= enabled && (ticks_elapsed <= window_ticks) && !opcode[2];
      end
      if (cfg_xfer && cfg_index == REG_WINDOW) begin
        window_ticks <= (cfg_data > WINDOW_MAX) ? WINDOW_MAX : cfg_data;
      end
      if (cfg_xfer && cfg_index == REG_ENABLED) begin
        enabled <= cfg_data[0];
      end
      if (clear || (cfg_xfer && cfg_index == REG_ENABLED)) begin
        entry_count   <= '0;
        ovf_rd        <= 64'd0;
        ovf_wr        <= 64'd0;
        ticks_elapsed <= 14'd0;
      end else begin
        if (ctrl.ins) begin
          entry_count <= entry_count + CW'(1);
        end else if (ctrl.drain) begin
          entry_count <= entry_count - CW'(1);
        end
        if (ovf_add && lat_rd) begin
          ovf_rd <= ovf_rd + {32'd0, lat_bytes};
        end
        if (ovf_add && lat_wr) begin
          ovf_wr <= ovf_wr + {32'd0, lat_bytes};
        end
        if (accept && mode == MODE_TICK && ticks_elapsed != TICK_SAT) begin
          ticks_elapsed <= ticks_elapsed + 14'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      lat_pid   <= process_id;
      lat_start <= start_time;
      lat_bytes <= access_bytes;
      lat_rd    <= (opcode == OP_READ);
      lat_wr    <= (opcode == OP_WRITE);
    end
    if (emit) begin
      row_kind       <= kind_next;
      row_process_id <= pid_next;
      read_kb        <= rd_next[63:KB_SHIFT];
      write_kb       <= wr_next[63:KB_SHIFT];
      last_row       <= last_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_hit_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hits))
    else $error("more than one slot matches the key");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == ST_DRAIN || state == ST_TAIL))
    else $error("result strobe outside readout");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_row) |-> (entry_count == '0 && !ovf_nz))
    else $error("table not cleared after final row");

endmodule

// ----- dv/ppioba_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppioba_checker
// Watches item, config and row transfers of the io byte accounting core.
// It keeps its own copy of the per-process table, predicts every readout
// row and compares each row field by field against the oldest one due.
// ----------------------------------------------------------------------------
module ppioba_checker
  import ppioba_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  mode,
  input  logic [21:0] process_id,
  input  logic [63:0] start_time,
  input  logic [2:0]  opcode,
  input  logic [31:0] access_bytes,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [13:0] cfg_data,
  input  logic        result_valid,
  input  logic [1:0]  row_kind,
  input  logic [21:0] row_process_id,
  input  logic [53:0] read_kb,
  input  logic [53:0] write_kb,
  input  logic        last_row,
  output int          fail_count,
  output int          rows_pending
);

  localparam logic [2:0] OP_FLUSH   = 3'd2;
  localparam logic [2:0] OP_DISCARD = 3'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [21:0] pid;
    logic [53:0] rd_kb;
    logic [53:0] wr_kb;
    logic        is_last;
  } row_t;

  row_t        rows_due[$];
  logic        acct_on;
  logic [13:0] win_limit;
  logic [13:0] ticks;
  logic [21:0] tbl_pid[DEPTH];
  logic [63:0] tbl_start[DEPTH];
  logic [63:0] tbl_bytes[DEPTH][4];
  int          tbl_used;
  logic [63:0] spill_bytes[4];
  int          errs;

  function automatic void reopen_window();
    tbl_used = 0;
    foreach (spill_bytes[k]) spill_bytes[k] = '0;
    ticks = '0;
  endfunction

  function automatic void tally_access(logic [21:0] pid, logic [63:0] st, logic [2:0] op,
                                       logic [31:0] nbytes);
    logic [63:0] size;
    int          hit;
    if (!acct_on || ticks > win_limit || op > OP_DISCARD) return;
    size = (op == OP_FLUSH) ? 64'd1 : {32'd0, nbytes};
    hit = -1;
    for (int i = 0; i < tbl_used; i++) begin
      if (hit < 0 && tbl_pid[i] == pid && tbl_start[i] == st) hit = i;
    end
    if (hit >= 0) begin
      tbl_bytes[hit][op[1:0]] += size;
    end else if (tbl_used < DEPTH) begin
      tbl_pid[tbl_used] = pid;
      tbl_start[tbl_used] = st;
      for (int k = 0; k < 4; k++) tbl_bytes[tbl_used][k] = '0;
      tbl_bytes[tbl_used][op[1:0]] = size;
      tbl_used++;
    end else begin
      spill_bytes[op[1:0]] += size;
    end
  endfunction

  function automatic void queue_readout();
    row_t r;
    int   emitted;
    emitted = 0;
    for (int i = tbl_used - 1; i >= 0; i--) begin
      r.kind = KIND_ENTRY;
      r.pid = tbl_pid[i];
      r.rd_kb = 54'(tbl_bytes[i][OP_READ] >> KB_SHIFT);
      r.wr_kb = 54'(tbl_bytes[i][OP_WRITE] >> KB_SHIFT);
      r.is_last = 1'b0;
      rows_due.push_back(r);
      emitted++;
    end
    if (spill_bytes[OP_READ] != 0 || spill_bytes[OP_WRITE] != 0) begin
      r.kind = KIND_OVERFLOW;
      r.pid = '0;
      r.rd_kb = 54'(spill_bytes[OP_READ] >> KB_SHIFT);
      r.wr_kb = 54'(spill_bytes[OP_WRITE] >> KB_SHIFT);
      r.is_last = 1'b0;
      rows_due.push_back(r);
      emitted++;
    end
    if (emitted == 0) begin
      r = '0;
      r.kind = KIND_EMPTY;
      rows_due.push_back(r);
    end
    r = rows_due.pop_back();
    r.is_last = 1'b1;
    rows_due.push_back(r);
    reopen_window();
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errs++;
      if (errs <= 10) $display("row mismatch on %s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    row_t want;
    if (rst) begin
      acct_on = 1'b0;
      win_limit = WINDOW_RESET;
      tbl_used = 0;
      foreach (spill_bytes[k]) spill_bytes[k] = '0;
      ticks = TICK_SAT;
      rows_due.delete();
      errs = 0;
    end else begin
      if (result_valid) begin
        if (rows_due.size() == 0) begin
          errs++;
          if (errs <= 10) begin
            $display("unexpected row: kind %0d id %0h", row_kind, row_process_id);
          end
        end else begin
          want = rows_due.pop_front();
          check_field("row_kind", want.kind, row_kind);
          check_field("row_process_id", want.pid, row_process_id);
          check_field("read_kb", want.rd_kb, read_kb);
          check_field("write_kb", want.wr_kb, write_kb);
          check_field("last_row", want.is_last, last_row);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ENABLED) begin
          acct_on = cfg_data[0];
          reopen_window();
        end else begin
          win_limit = (cfg_data > WINDOW_MAX) ? WINDOW_MAX : cfg_data;
        end
      end
      if (start && !busy) begin
        case (mode)
          MODE_ACCESS: tally_access(process_id, start_time, opcode, access_bytes);
          MODE_TICK: begin
            if (ticks != TICK_SAT) ticks++;
          end
          MODE_READOUT: queue_readout();
          default: reopen_window();
        endcase
      end
    end
    fail_count <= errs;
    rows_pending <= rows_due.size();
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the per-process io byte accounting core.
// Drives directed and random access, tick, readout and restart items with
// random pacing across several register settings; the checker beside the
// core predicts and compares every readout row.
// ----------------------------------------------------------------------------
module tb_top;
  import ppioba_pkg::*;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode = MODE_ACCESS;
  logic [21:0] process_id = '0;
  logic [63:0] start_time = '0;
  logic [2:0]  opcode = OP_READ;
  logic [31:0] access_bytes = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_ENABLED;
  logic [13:0] cfg_data = '0;
  logic        result_valid;
  logic [1:0]  row_kind;
  logic [21:0] row_process_id;
  logic [53:0] read_kb;
  logic [53:0] write_kb;
  logic        last_row;
  int          fail_count;
  int          rows_pending;
  logic        pace_on = 1'b1;
  logic [21:0] key_pid[48];
  logic [63:0] key_start[48];

  per_process_io_byte_accounting_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .process_id     (process_id),
    .start_time     (start_time),
    .opcode         (opcode),
    .access_bytes   (access_bytes),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .result_valid   (result_valid),
    .row_kind       (row_kind),
    .row_process_id (row_process_id),
    .read_kb        (read_kb),
    .write_kb       (write_kb),
    .last_row       (last_row)
  );

  ppioba_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .process_id     (process_id),
    .start_time     (start_time),
    .opcode         (opcode),
    .access_bytes   (access_bytes),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .result_valid   (result_valid),
    .row_kind       (row_kind),
    .row_process_id (row_process_id),
    .read_kb        (read_kb),
    .write_kb       (write_kb),
    .last_row       (last_row),
    .fail_count     (fail_count),
    .rows_pending   (rows_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL per_process_io_byte_accounting_core");
    $finish;
  end

  // start stays high after a transfer; the next call lowers it or reuses it
  task automatic send_item(input logic [1:0] m, input logic [21:0] p, input logic [63:0] s,
                           input logic [2:0] o, input logic [31:0] b);
    int gap;
    gap = pace_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= m;
    process_id <= p;
    start_time <= s;
    opcode <= o;
    access_bytes <= b;
    do @(posedge clk); while (busy);
  endtask

  task automatic set_config(input logic en, input logic [13:0] win);
    cfg_valid <= 1'b1;
    cfg_index <= REG_WINDOW;
    cfg_data <= win;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_ENABLED;
    cfg_data <= {13'($urandom), en};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic run_phase(input int n_items, input int n_keys, input int rd_pct,
                           input int tick_pct, input int clr_pct);
    int          r;
    int          k;
    logic [2:0]  op;
    logic [31:0] sz;
    logic [21:0] p;
    logic [63:0] s;
    for (int i = 0; i < n_keys; i++) begin
      key_pid[i] = (i > 0 && $urandom_range(0, 5) == 0) ? key_pid[i-1] : 22'($urandom);
      key_start[i] = (i > 0 && $urandom_range(0, 5) == 0) ? key_start[i-1]
                                                           : {$urandom, $urandom};
    end
    for (int i = 0; i < n_items; i++) begin
      if (i % 16 == 0) pace_on = ($urandom_range(0, 2) != 0);
      r = $urandom_range(0, 99);
      p = 22'($urandom);
      s = {$urandom, $urandom};
      op = ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: sz = $urandom;
        1: sz = $urandom_range(0, 4095);
        2: sz = '1;
        default: sz = $urandom_range(1024, 1 << 20);
      endcase
      if (r < rd_pct) begin
        send_item(MODE_READOUT, p, s, op, sz);
      end else if (r < rd_pct + tick_pct) begin
        send_item(MODE_TICK, p, s, op, sz);
      end else if (r < rd_pct + tick_pct + clr_pct) begin
        send_item(MODE_RESTART, p, s, op, sz);
      end else begin
        if ($urandom_range(0, 9) != 0) begin
          k = $urandom_range(0, n_keys - 1);
          p = key_pid[k];
          s = key_start[k];
        end
        send_item(MODE_ACCESS, p, s, op, sz);
      end
    end
    send_item(MODE_READOUT, '0, '0, OP_READ, '0);
    settle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // disabled and window closed after reset
    send_item(MODE_ACCESS, '1, '1, OP_READ, '1);
    send_item(MODE_READOUT, '0, '0, OP_READ, '0);
    settle();

    set_config(1'b1, 14'h3fff);
    for (int o = 0; o < 8; o++) send_item(MODE_ACCESS, '1, '1, 3'(o), '1);
    send_item(MODE_ACCESS, '0, '0, OP_READ, '0);
    send_item(MODE_ACCESS, '0, '1, OP_WRITE, 32'd1024);
    send_item(MODE_ACCESS, '1, '0, OP_READ, 32'd2047);
    send_item(MODE_ACCESS, '1, '1, OP_READ, 32'd1);
    send_item(MODE_READOUT, '0, '0, OP_READ, '0);
    send_item(MODE_READOUT, '1, '1, OP_READ, '1);
    settle();

    // window edge with a short window
    set_config(1'b1, 14'd2);
    send_item(MODE_TICK, '0, '0, OP_READ, '0);
    send_item(MODE_TICK, '0, '0, OP_READ, '0);
    send_item(MODE_ACCESS, 22'h15, 64'h99, OP_READ, 32'd4096);
    send_item(MODE_TICK, '0, '0, OP_READ, '0);
    send_item(MODE_ACCESS, 22'h2a, 64'h77, OP_WRITE, 32'd4096);
    send_item(MODE_READOUT, '0, '0, OP_READ, '0);
    send_item(MODE_TICK, '0, '0, OP_READ, '0);
    send_item(MODE_RESTART, '0, '0, OP_READ, '0);
    send_item(MODE_ACCESS, 22'h2a, 64'h77, OP_WRITE, 32'd8192);
    send_item(MODE_READOUT, '0, '0, OP_READ, '0);
    settle();

    // window boundary with back-to-back ticks
    set_config(1'b1, 14'd12);
    pace_on = 1'b0;
    send_item(MODE_RESTART, '0, '0, OP_READ, '0);
    repeat (12) send_item(MODE_TICK, '0, '0, OP_READ, '0);
    send_item(MODE_ACCESS, 22'h1, 64'h1, OP_READ, 32'd1048576);
    send_item(MODE_TICK, '0, '0, OP_READ, '0);
    send_item(MODE_ACCESS, 22'h2, 64'h2, OP_READ, 32'd1048576);
    repeat (3) send_item(MODE_TICK, '0, '0, OP_READ, '0);
    send_item(MODE_ACCESS, 22'h3, 64'h3, OP_WRITE, 32'd1048576);
    send_item(MODE_READOUT, '0, '0, OP_READ, '0);
    settle();
    pace_on = 1'b1;

    set_config(1'b1, WINDOW_MAX);
    run_phase(50, 12, 8, 3, 2);
    set_config(1'b1, 14'h3fff);
    run_phase(80, 48, 0, 0, 0);
    set_config(1'b1, 14'd0);
    run_phase(30, 8, 10, 10, 8);
    set_config(1'b0, WINDOW_RESET);
    run_phase(30, 8, 15, 5, 5);
    set_config(1'b1, 14'($urandom_range(1, 20)));
    run_phase(40, 20, 8, 15, 6);
    set_config(1'b1, WINDOW_MAX);
    run_phase(30, 40, 5, 2, 2);

    if (fail_count == 0 && rows_pending == 0) begin
      $display("PASS per_process_io_byte_accounting_core");
    end else begin
      $display("FAIL per_process_io_byte_accounting_core");
    end
    $finish;
  end

endmodule
